FILE: rtl/assert_macros.svh
// assertion macros used by rtl/lru_k_block_cache.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// implication whose consequent is checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/lkbc_pkg.sv
// shared types and constants for the lru-k block cache
// no dependencies
package lkbc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam logic [6:0] CAP_RESET = 7'd64;
  localparam logic [7:0] K_RESET = 8'd2;
  localparam logic [7:0] K_MIN = 8'd2;
  localparam logic [7:0] USES_MAX = 8'hff;
  localparam logic [31:0] CNT_MAX = 32'hffff_ffff;

  // register byte addresses
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam logic [2:0] ADDR_THRESHOLD = 3'd4;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_FREE,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/lru_k_block_cache.sv
// lru-k block cache: fully associative, two recency classes, memory based
// A request is accepted in IDLE; SCAN then reads one slot per cycle over the whole slot
// memory. A lookup or update then goes to WRITE and OUT, an insert into a free slot
// passes FREE first, and an insert that evicts a victim passes EVICT and FREE. One
// request in flight; the next one is accepted back in IDLE after the result transaction.
// Synchronous active-low reset clears valid bits, clock, counters; payloads not cleared.
`include "assert_macros.svh"

module lru_k_block_cache #(
  parameter int ENTRIES = lkbc_pkg::ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [30:0] table_id, [61:31] block_index, [93:62] block_handle, zero fill
  input  logic [95:0]  in_tdata,
  // [0] req_type
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] data_out, [63:32] lookup_count, [95:64] lookup_hits
  output logic [95:0]  out_tdata,
  // [0] hit
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW:0] LAST = (IW + 1)'(ENTRIES - 1);

  // slot memory: key, handle, uses, recency
  logic [30:0] mem_tab [ENTRIES];
  logic [30:0] mem_blk [ENTRIES];
  logic [31:0] mem_hdl [ENTRIES];
  logic [7:0]  mem_use [ENTRIES];
  logic [31:0] mem_rec [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic [30:0] rd_tab_r;
  logic [30:0] rd_blk_r;
  logic [31:0] rd_hdl_r;
  logic [7:0]  rd_use_r;
  logic [31:0] rd_rec_r;

  lkbc_pkg::state_t state_r, state_nxt;
  logic [6:0]  cap_r;
  logic [7:0]  k_r;
  logic [31:0] clock_r, clock_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic [31:0] hits_r, hits_nxt;

  // request registers
  logic        put_r;
  logic [30:0] tid_r;
  logic [30:0] bid_r;
  logic [31:0] hdl_r;

  // scan control
  logic [IW:0] ridx_r, ridx_nxt;     // read address issued
  logic        rvld_r, rvld_nxt;     // read data valid this cycle
  logic [IW-1:0] cidx_r;             // index of rd data
  logic        found_r, found_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic        vr_r, vr_nxt, vf_r, vf_nxt;
  logic [IW-1:0] vri_r, vri_nxt, vfi_r, vfi_nxt;
  logic [31:0] var_r, var_nxt, vaf_r, vaf_nxt;
  logic        free_r, free_nxt;
  logic [IW-1:0] fri_r, fri_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic        ohit_r, ohit_nxt;
  logic [31:0] odat_r, odat_nxt;

  // memory write controls
  logic        we;
  logic        we_new;
  logic [IW-1:0] wa;
  logic [7:0]  wuse;
  logic [31:0] whdl;

  logic [7:0]  k_eff;
  logic [6:0]  cap_eff;
  logic        cap_big;
  logic [IW-1:0] raddr;
  logic        re;
  logic        rvalid_bit;
  logic [31:0] age;
  logic        freq;
  logic        cfg_wr;

  assign k_eff = (k_r < lkbc_pkg::K_MIN) ? lkbc_pkg::K_MIN : k_r;
  assign cap_big = (32'(cap_r) > 32'(ENTRIES));
  assign cap_eff = (cap_r == 7'd0) ? 7'd1 : cap_r;
  assign raddr = ridx_r[IW-1:0];
  assign rvalid_bit = valid_r[cidx_r];
  assign age = clock_r - rd_rec_r;
  assign freq = (rd_use_r >= k_eff);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr)
      lkbc_pkg::ADDR_CAPACITY:  cfg_prdata = {25'd0, cap_r};
      lkbc_pkg::ADDR_THRESHOLD: cfg_prdata = {24'd0, k_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkbc_pkg::CAP_RESET;
      k_r <= lkbc_pkg::K_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr == lkbc_pkg::ADDR_CAPACITY) cap_r <= cfg_pwdata[6:0];
      if (cfg_paddr == lkbc_pkg::ADDR_THRESHOLD) k_r <= cfg_pwdata[7:0];
    end
  end

  // handshake
  assign in_tready = (state_r == lkbc_pkg::ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tuser = ohit_r;
  assign out_tdata = {hits_r, tot_r, odat_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkbc_pkg::ST_IDLE:  if (in_tvalid && in_tready) state_nxt = lkbc_pkg::ST_SCAN;
      lkbc_pkg::ST_SCAN: begin
        if (rvld_r && cidx_r == LAST[IW-1:0]) begin
          if (found_nxt || !put_r) state_nxt = lkbc_pkg::ST_WRITE;
          else if (cap_big ? (32'(occ_nxt) >= 32'(ENTRIES))
                           : (32'(occ_nxt) >= 32'(cap_eff)))
            state_nxt = lkbc_pkg::ST_EVICT;
          else state_nxt = lkbc_pkg::ST_FREE;
        end
      end
      lkbc_pkg::ST_EVICT: state_nxt = lkbc_pkg::ST_FREE;
      lkbc_pkg::ST_FREE:  state_nxt = lkbc_pkg::ST_WRITE;
      lkbc_pkg::ST_WRITE: state_nxt = lkbc_pkg::ST_OUT;
      lkbc_pkg::ST_OUT:   if (!ov_r) state_nxt = lkbc_pkg::ST_IDLE;
      default:            state_nxt = lkbc_pkg::ST_IDLE;
    endcase
  end

  // scan datapath: one slot compared per cycle
  always_comb begin
    ridx_nxt = ridx_r;
    rvld_nxt = 1'b0;
    re = 1'b0;
    found_nxt = found_r;
    fidx_nxt = fidx_r;
    occ_nxt = occ_r;
    vr_nxt = vr_r; vri_nxt = vri_r; var_nxt = var_r;
    vf_nxt = vf_r; vfi_nxt = vfi_r; vaf_nxt = vaf_r;
    if (state_r == lkbc_pkg::ST_IDLE) begin
      ridx_nxt = '0;
      found_nxt = 1'b0;
      occ_nxt = '0;
      vr_nxt = 1'b0;
      vf_nxt = 1'b0;
    end else if (state_r == lkbc_pkg::ST_SCAN) begin
      if (ridx_r <= LAST) begin
        re = 1'b1;
        rvld_nxt = 1'b1;
        ridx_nxt = ridx_r + 1'b1;
      end
      if (rvld_r && rvalid_bit) begin
        occ_nxt = occ_r + 1'b1;
        if (!found_r && rd_tab_r == tid_r && rd_blk_r == bid_r) begin
          found_nxt = 1'b1;
          fidx_nxt = cidx_r;
        end
        if (!freq && (!vr_r || age > var_r)) begin
          vr_nxt = 1'b1; vri_nxt = cidx_r; var_nxt = age;
        end
        if (freq && (!vf_r || age > vaf_r)) begin
          vf_nxt = 1'b1; vfi_nxt = cidx_r; vaf_nxt = age;
        end
      end
    end
  end

  // free slot search over the valid bits: priority encode, lowest first
  always_comb begin
    free_nxt = 1'b0;
    fri_nxt = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_nxt = 1'b1;
        fri_nxt = IW'(i);
      end
    end
  end

  // write-back, counters and result
  always_comb begin
    valid_nxt = valid_r;
    clock_nxt = clock_r;
    tot_nxt = tot_r;
    hits_nxt = hits_r;
    ov_nxt = ov_r;
    ohit_nxt = ohit_r;
    odat_nxt = odat_r;
    we = 1'b0;
    we_new = 1'b0;
    wa = fidx_r;
    wuse = (rd_use_r == lkbc_pkg::USES_MAX) ? rd_use_r : rd_use_r + 8'd1;
    whdl = put_r ? hdl_r : rd_hdl_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    if (state_r == lkbc_pkg::ST_EVICT) begin
      if (vr_r) valid_nxt[vri_r] = 1'b0;
      else if (vf_r) valid_nxt[vfi_r] = 1'b0;
    end
    if (state_r == lkbc_pkg::ST_WRITE) begin
      ohit_nxt = found_r;
      odat_nxt = 32'd0;
      ov_nxt = 1'b1;
      if (!put_r) begin
        if (tot_r != lkbc_pkg::CNT_MAX) tot_nxt = tot_r + 32'd1;
        if (found_r) begin
          if (hits_r != lkbc_pkg::CNT_MAX) hits_nxt = hits_r + 32'd1;
          odat_nxt = rd_hdl_r;
          we = 1'b1;
          clock_nxt = clock_r + 32'd1;
        end
      end else if (found_r) begin
        we = 1'b1;
        clock_nxt = clock_r + 32'd1;
      end else if (free_r) begin
        we = 1'b1;
        we_new = 1'b1;
        wa = fri_r;
        wuse = 8'd1;
        valid_nxt[fri_r] = 1'b1;
        clock_nxt = clock_r + 32'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkbc_pkg::ST_IDLE;
      valid_r <= '0;
      clock_r <= '0;
      tot_r <= '0;
      hits_r <= '0;
      ov_r <= 1'b0;
      rvld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      clock_r <= clock_nxt;
      tot_r <= tot_nxt;
      hits_r <= hits_nxt;
      ov_r <= ov_nxt;
      rvld_r <= rvld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ridx_r <= ridx_nxt;
    cidx_r <= raddr;
    found_r <= found_nxt;
    fidx_r <= fidx_nxt;
    occ_r <= occ_nxt;
    vr_r <= vr_nxt; vri_r <= vri_nxt; var_r <= var_nxt;
    vf_r <= vf_nxt; vfi_r <= vfi_nxt; vaf_r <= vaf_nxt;
    ohit_r <= ohit_nxt;
    odat_r <= odat_nxt;
    if (state_r == lkbc_pkg::ST_FREE) begin
      free_r <= free_nxt;
      fri_r <= fri_nxt;
    end
    if (in_tvalid && in_tready) begin
      put_r <= in_tuser;
      tid_r <= in_tdata[30:0];
      bid_r <= in_tdata[61:31];
      hdl_r <= in_tdata[93:62];
    end
  end

  // slot memory: one read port during scan, write port at write-back;
  // a found slot's handle and uses are reread at the end of the scan to refresh rd data
  always_ff @(posedge clk) begin
    if (re) begin
      rd_tab_r <= mem_tab[raddr];
      rd_blk_r <= mem_blk[raddr];
      rd_hdl_r <= mem_hdl[raddr];
      rd_use_r <= mem_use[raddr];
      rd_rec_r <= mem_rec[raddr];
    end else if (state_r == lkbc_pkg::ST_SCAN) begin
      rd_hdl_r <= mem_hdl[fidx_nxt];
      rd_use_r <= mem_use[fidx_nxt];
    end
    if (we) begin
      mem_hdl[wa] <= whdl;
      mem_use[wa] <= wuse;
      mem_rec[wa] <= clock_r;
      if (we_new) begin
        mem_tab[wa] <= tid_r;
        mem_blk[wa] <= bid_r;
      end
    end
  end

  // checks
  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, state_r == lkbc_pkg::ST_IDLE)
  `ASSERT_NEXT(a_write_gives_result, clk, rst_n, state_r == lkbc_pkg::ST_WRITE, ov_r)
  `ASSERT_IMPL(a_new_into_free, clk, rst_n, we_new, !valid_r[wa])
  `ASSERT_IMPL(a_hits_le_total, clk, rst_n, ov_r, hits_r <= tot_r)

endmodule

FILE: tb/tb_lru_k_block_cache.sv
// testbench for the lru-k block cache: random and directed requests against a
// behavioral cache predictor, apb register writes between phases
// depends on rtl/lkbc_pkg.sv and rtl/lru_k_block_cache.sv
`timescale 1ns / 100ps

module tb_lru_k_block_cache;

  localparam int N = 64;
  localparam int WD_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  lru_k_block_cache u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic hit;
    logic [31:0] data;
    logic [31:0] lookups;
    logic [31:0] hits;
  } resp_t;

  // cache predictor state
  logic        c_valid [N];
  logic [30:0] c_table [N];
  logic [30:0] c_block [N];
  logic [31:0] c_handle [N];
  logic [7:0]  c_uses [N];
  logic [31:0] c_stamp [N];
  logic [31:0] c_clock, c_lookups, c_hits;
  logic [6:0]  cap_reg;
  logic [7:0]  k_reg;

  resp_t expected_q[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int quiet = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic int oldest_slot(input bit freq);
    int best;
    logic [31:0] best_age, age;
    logic [7:0] k;
    best = -1;
    best_age = '0;
    k = (k_reg < lkbc_pkg::K_MIN) ? lkbc_pkg::K_MIN : k_reg;
    for (int i = 0; i < N; i++) begin
      if (c_valid[i] && ((c_uses[i] >= k) == freq)) begin
        age = c_clock - c_stamp[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic resp_t predict_cache(input logic put, input logic [30:0] tid,
                                          input logic [30:0] bid, input logic [31:0] h);
    resp_t r;
    int found, occ, v, s, cap;
    found = -1;
    occ = 0;
    r = '0;
    for (int i = 0; i < N; i++) begin
      if (c_valid[i]) begin
        occ++;
        if (found < 0 && c_table[i] == tid && c_block[i] == bid) found = i;
      end
    end
    r.hit = (found >= 0);
    if (put == lkbc_pkg::REQ_GET) begin
      if (c_lookups != lkbc_pkg::CNT_MAX) c_lookups++;
      if (found >= 0) begin
        if (c_hits != lkbc_pkg::CNT_MAX) c_hits++;
        if (c_uses[found] != lkbc_pkg::USES_MAX) c_uses[found]++;
        c_stamp[found] = c_clock;
        c_clock++;
        r.data = c_handle[found];
      end
    end else if (found >= 0) begin
      c_handle[found] = h;
      if (c_uses[found] != lkbc_pkg::USES_MAX) c_uses[found]++;
      c_stamp[found] = c_clock;
      c_clock++;
    end else begin
      cap = (cap_reg < 1) ? 1 : (cap_reg > N) ? N : int'(cap_reg);
      if (occ >= cap) begin
        v = oldest_slot(1'b0);
        if (v < 0) v = oldest_slot(1'b1);
        if (v >= 0) c_valid[v] = 1'b0;
      end
      s = 0;
      while (s < N && c_valid[s]) s++;
      if (s < N) begin
        c_valid[s] = 1'b1;
        c_table[s] = tid;
        c_block[s] = bid;
        c_handle[s] = h;
        c_uses[s] = 8'd1;
        c_stamp[s] = c_clock;
        c_clock++;
      end
    end
    r.lookups = c_lookups;
    r.hits = c_hits;
    return r;
  endfunction

  // send one request and queue its expected response
  task automatic send_req(input logic put, input logic [30:0] tid, input logic [30:0] bid,
                          input logic [31:0] h);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= put;
    in_tdata <= {2'b00, h, bid, tid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_cache(put, tid, bid, h));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * N + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == lkbc_pkg::ADDR_CAPACITY) cap_reg = val[6:0];
    else k_reg = val[7:0];
    @(posedge clk);
  endtask

  // response checker
  always @(posedge clk) begin
    resp_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected response transaction", 32'd1, 32'd0);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tuser !== exp_r.hit) report("hit", 32'(out_tuser), 32'(exp_r.hit));
          if (out_tdata[31:0] !== exp_r.data) report("data_out", out_tdata[31:0], exp_r.data);
          if (out_tdata[63:32] !== exp_r.lookups)
            report("lookup_count", out_tdata[63:32], exp_r.lookups);
          if (out_tdata[95:64] !== exp_r.hits)
            report("lookup_hits", out_tdata[95:64], exp_r.hits);
        end
      end
    end
  end

  // random stall bursts on the result side
  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_on) out_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT + 4 * N) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // keys from a small pool so hits and evictions happen often
  function automatic logic [30:0] pool_key(input int n);
    return (n == 0) ? 31'h7fff_ffff : 31'(n);
  endfunction

  task automatic test_directed();
    send_req(lkbc_pkg::REQ_GET, 31'd0, 31'd0, 32'h0);
    send_req(lkbc_pkg::REQ_PUT, 31'd0, 31'd0, 32'h0);
    send_req(lkbc_pkg::REQ_GET, 31'd0, 31'd0, 32'hffff_ffff);
    send_req(lkbc_pkg::REQ_PUT, 31'h7fff_ffff, 31'h7fff_ffff, 32'hffff_ffff);
    send_req(lkbc_pkg::REQ_GET, 31'h7fff_ffff, 31'h7fff_ffff, 32'h0);
    send_req(lkbc_pkg::REQ_PUT, 31'h7fff_ffff, 31'h7fff_ffff, 32'h1234_5678);
    send_req(lkbc_pkg::REQ_GET, 31'h7fff_ffff, 31'd0, 32'h0);
    send_req(lkbc_pkg::REQ_GET, 31'h7fff_ffff, 31'h7fff_ffff, 32'h0);
    send_req(lkbc_pkg::REQ_PUT, 31'h5555_5555, 31'h2aaa_aaaa, 32'haaaa_5555);
    send_req(lkbc_pkg::REQ_GET, 31'h5555_5555, 31'h2aaa_aaaa, 32'h0);
    drain();
  endtask

  // capacity 1 and 2: eviction of recent then frequent entries, lowered capacity
  task automatic test_small_capacity();
    write_reg(lkbc_pkg::ADDR_CAPACITY, 32'd2);
    write_reg(lkbc_pkg::ADDR_THRESHOLD, 32'd0);
    for (int i = 0; i < 12; i++)
      send_req(1'($urandom_range(0, 1)), 31'($urandom_range(1, 4)), 31'd3, $urandom);
    drain();
    write_reg(lkbc_pkg::ADDR_CAPACITY, 32'd0);
    for (int i = 0; i < 8; i++)
      send_req(1'($urandom_range(0, 1)), 31'($urandom_range(1, 3)), 31'd3, $urandom);
    drain();
  endtask

  task automatic random_phase(input int items, input int keys);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_req(1'($urandom_range(0, 1)), 31'($urandom), 31'($urandom), $urandom);
      else
        send_req(1'($urandom_range(0, 1)), pool_key($urandom_range(0, keys)),
                 31'($urandom_range(0, 3)), $urandom);
    end
  endtask

  task automatic test_random();
    write_reg(lkbc_pkg::ADDR_CAPACITY, 32'd8);
    write_reg(lkbc_pkg::ADDR_THRESHOLD, 32'd3);
    random_phase(300, 10);
    drain();
    write_reg(lkbc_pkg::ADDR_CAPACITY, 32'd127);
    write_reg(lkbc_pkg::ADDR_THRESHOLD, 32'd254);
    random_phase(300, 30);
    drain();
    write_reg(lkbc_pkg::ADDR_CAPACITY, 32'd64);
    write_reg(lkbc_pkg::ADDR_THRESHOLD, 32'd255);
    for (int i = 0; i < 20; i++) send_req(lkbc_pkg::REQ_GET, 31'h7fff_ffff, 31'd1, 32'h0);
    random_phase(200, 30);
    drain();
    write_reg(lkbc_pkg::ADDR_CAPACITY, 32'd5);
    write_reg(lkbc_pkg::ADDR_THRESHOLD, 32'd2);
    random_phase(150, 8);
    drain();
  endtask

  task automatic test_full_rate();
    write_reg(lkbc_pkg::ADDR_CAPACITY, 32'd1);
    idle_on = 1'b0;
    random_phase(150, 4);
  endtask

  initial begin
    cap_reg = lkbc_pkg::CAP_RESET;
    k_reg = lkbc_pkg::K_RESET;
    c_clock = '0;
    c_lookups = '0;
    c_hits = '0;
    for (int i = 0; i < N; i++) begin
      c_valid[i] = 1'b0;
      c_uses[i] = '0;
      c_stamp[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_capacity();
    test_random();
    test_full_rate();
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lkbc_pkg.sv
rtl/lru_k_block_cache.sv
tb/tb_lru_k_block_cache.sv
